// ----- src/jsv_pkg.sv -----
// shared types and constants for the json structure validator
// no dependencies; imported by every module of the block
package jsv_pkg;

   // fixed field widths
   localparam int CH_W    = 16;
   localparam int DEPTH_W = 6;
   localparam int ERR_W   = 3;
   localparam int EV_W    = 4;

   // largest stack pointer value the depth field and the limit register can hold
   localparam int DEPTH_CAP = (2 ** DEPTH_W) - 1;

   // request queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // reset value of the depth limit register
   localparam logic [DEPTH_W-1:0] LIMIT_RESET = DEPTH_W'(32);

   // structural characters
   localparam logic [7:0] ASCII_LBRACE = 8'h7B;
   localparam logic [7:0] ASCII_RBRACE = 8'h7D;
   localparam logic [7:0] ASCII_LBRACK = 8'h5B;
   localparam logic [7:0] ASCII_RBRACK = 8'h5D;
   localparam logic [7:0] ASCII_COLON  = 8'h3A;
   localparam logic [7:0] ASCII_COMMA  = 8'h2C;
   localparam logic [7:0] ASCII_SPACE  = 8'h20;
   localparam logic [7:0] ASCII_TAB    = 8'h09;
   localparam logic [7:0] ASCII_QUOTE  = 8'h22;

   // character class found by the front
   typedef enum logic [3:0] {
      CL_BLANK,
      CL_LBRACE,
      CL_RBRACE,
      CL_LBRACK,
      CL_RBRACK,
      CL_COLON,
      CL_COMMA,
      CL_QUOTE,
      CL_OTHER
   } class_type;

   // stack frame codes
   typedef enum logic [3:0] {
      FR_OBJ_OPEN  = 4'd0,
      FR_OBJ_DONE  = 4'd1,
      FR_FLD_KEY   = 4'd2,
      FR_FLD_COLON = 4'd3,
      FR_FLD_VALUE = 4'd4,
      FR_ARR_OPEN  = 4'd5,
      FR_ARR_DONE  = 4'd6,
      FR_STR       = 4'd7,
      FR_KEY       = 4'd8
   } frame_type;

   // structural event codes
   typedef enum logic [EV_W-1:0] {
      EV_BLANK     = 4'd0,
      EV_OBJ_OPEN  = 4'd1,
      EV_OBJ_CLOSE = 4'd2,
      EV_ARR_OPEN  = 4'd3,
      EV_ARR_CLOSE = 4'd4,
      EV_KEY_START = 4'd5,
      EV_KEY_CHAR  = 4'd6,
      EV_KEY_END   = 4'd7,
      EV_STR_START = 4'd8,
      EV_STR_CHAR  = 4'd9,
      EV_STR_END   = 4'd10,
      EV_COLON     = 4'd11,
      EV_COMMA     = 4'd12,
      EV_ERROR     = 4'd13,
      EV_FINISHED  = 4'd14
   } event_type;

   // error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_UNEXPECTED = 3'd1,
      ERR_BRACKET    = 3'd2,
      ERR_DEPTH      = 3'd3,
      ERR_UNCLOSED   = 3'd4,
      ERR_EMPTY      = 3'd5
   } err_type;

   // stack action chosen for one character
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH1,
      ACT_PUSH2,
      ACT_SET_TOP,
      ACT_CLOSE
   } act_type;

   // stack shift for one step
   typedef enum logic [2:0] {
      SH_POP2,
      SH_POP1,
      SH_HOLD,
      SH_PUSH1,
      SH_PUSH2
   } shift_type;

   // parent frame update on a close
   typedef struct packed {
      logic      wr;
      frame_type v;
   } upd_type;

   // one classified request in the queue
   typedef struct packed {
      logic            cmd;
      class_type       cls;
      logic [CH_W-1:0] ch;
   } entry_type;

   // one result item
   typedef struct packed {
      event_type          ev;
      logic [CH_W-1:0]    char_out;
      logic [DEPTH_W-1:0] depth;
      err_type            code;
      logic               accepted;
   } result_type;

endpackage

// ----- src/jsv_front.sv -----
// front end: masks the incoming character and classifies it
// depends on jsv_pkg
module jsv_front import jsv_pkg::*; #(
   parameter int CHAR_BITS = 16
) (
   input  logic            cmd,
   input  logic [CH_W-1:0] ch,
   output entry_type       entry
);

   localparam int CW = (CHAR_BITS < CH_W) ? CHAR_BITS : CH_W;

   logic [CH_W-1:0] ch_mask;

   // keep only the character bits in use
   assign ch_mask = CH_W'(ch[CW-1:0]);

   // classify the character
   always_comb begin
      entry.cmd = cmd;
      entry.ch  = ch_mask;
      if (ch_mask == CH_W'(ASCII_SPACE) || ch_mask == CH_W'(ASCII_TAB)) begin
         entry.cls = CL_BLANK;
      end else if (ch_mask == CH_W'(ASCII_LBRACE)) begin
         entry.cls = CL_LBRACE;
      end else if (ch_mask == CH_W'(ASCII_RBRACE)) begin
         entry.cls = CL_RBRACE;
      end else if (ch_mask == CH_W'(ASCII_LBRACK)) begin
         entry.cls = CL_LBRACK;
      end else if (ch_mask == CH_W'(ASCII_RBRACK)) begin
         entry.cls = CL_RBRACK;
      end else if (ch_mask == CH_W'(ASCII_COLON)) begin
         entry.cls = CL_COLON;
      end else if (ch_mask == CH_W'(ASCII_COMMA)) begin
         entry.cls = CL_COMMA;
      end else if (ch_mask == CH_W'(ASCII_QUOTE)) begin
         entry.cls = CL_QUOTE;
      end else begin
         entry.cls = CL_OTHER;
      end
   end

endmodule

// ----- src/jsv_queue.sv -----
// short request queue between the front end and the stack engine
// depends on jsv_pkg
module jsv_queue import jsv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  entry_type wr_data,
   output logic      rd_valid,
   input  logic      rd_ready,
   output entry_type rd_data
);

   entry_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign wr_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/jsv_back.sv -----
// stack engine: runs the pushdown check for one request per cycle while the result
// register is empty or being read, and holds the result register; depends on jsv_pkg
module jsv_back import jsv_pkg::*; #(
   parameter int MAX_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [DEPTH_W-1:0] limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  entry_type          in_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output result_type         rsp_data
);

   localparam int EFF = (MAX_DEPTH < DEPTH_CAP) ? MAX_DEPTH : DEPTH_CAP;
   localparam int SPW = $clog2(EFF + 1);

   // shift-register stack, entry 0 is the top frame
   frame_type           stk_ff [EFF];
   frame_type           stk_in [EFF];
   frame_type           pad [EFF + 4];
   logic [SPW-1:0]      sp_ff, sp_in;
   logic                root_ff, root_in;
   err_type             err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic                fire;
   logic [DEPTH_W-1:0]  lim_eff;
   logic [DEPTH_W:0]    sp_need;
   logic [1:0]          need;

   // per-character decision
   event_type           ev;
   err_type             err;
   logic [CH_W-1:0]     echo;
   act_type             act;
   frame_type           val_a, val_b;
   logic                open_req;

   // close resolution
   shift_type           cl_sh;
   logic [SPW-1:0]      cl_sp;
   logic                cl_root;
   upd_type             cl_upd;
   upd_type             up1, up2;

   // step application
   shift_type           sh;
   logic                wr0, wr1;
   frame_type           v0, v1;
   err_type             code;
   logic                acc;

   function automatic upd_type parent_upd(frame_type t);
      upd_type u;
      u.wr = 1'b1;
      u.v  = t;
      case (t) inside
         FR_OBJ_OPEN, FR_OBJ_DONE: u.v = FR_OBJ_DONE;
         FR_FLD_KEY:               u.v = FR_FLD_COLON;
         FR_ARR_OPEN, FR_ARR_DONE: u.v = FR_ARR_DONE;
         default:                  u.wr = 1'b0;
      endcase
      return u;
   endfunction

   assign fire      = in_valid && in_ready;
   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective depth limit
   assign lim_eff = (limit > DEPTH_W'(EFF)) ? DEPTH_W'(EFF) : limit;

   // padded view of the stack for shifting
   always_comb begin
      for (int i = 0; i < EFF + 4; i++) begin
         pad[i] = FR_OBJ_OPEN;
      end
      for (int i = 0; i < EFF; i++) begin
         pad[i + 2] = stk_ff[i];
      end
   end

   // classify the step against the top frame
   always_comb begin
      ev       = EV_BLANK;
      err      = ERR_NONE;
      echo     = '0;
      act      = ACT_NONE;
      val_a    = FR_OBJ_OPEN;
      val_b    = FR_OBJ_OPEN;
      open_req = 1'b0;
      if (sp_ff == '0) begin
         if (!root_ff) begin
            open_req = 1'b1;
         end else if (in_data.cls != CL_BLANK) begin
            err = ERR_UNEXPECTED;
         end
      end else begin
         unique case (stk_ff[0]) inside
            FR_OBJ_OPEN, FR_OBJ_DONE: begin
               if (in_data.cls == CL_RBRACE) begin
                  act = ACT_CLOSE;
                  ev  = EV_OBJ_CLOSE;
               end else if (in_data.cls == CL_BLANK) begin
                  ev = EV_BLANK;
               end else if (stk_ff[0] == FR_OBJ_OPEN && in_data.cls == CL_QUOTE) begin
                  act   = ACT_PUSH2;
                  val_a = FR_FLD_KEY;
                  val_b = FR_KEY;
                  ev    = EV_KEY_START;
               end else if (stk_ff[0] == FR_OBJ_DONE && in_data.cls == CL_COMMA) begin
                  act   = ACT_SET_TOP;
                  val_a = FR_OBJ_OPEN;
                  ev    = EV_COMMA;
               end else begin
                  err = ERR_UNEXPECTED;
               end
            end
            FR_FLD_COLON: begin
               if (in_data.cls == CL_COLON) begin
                  act   = ACT_SET_TOP;
                  val_a = FR_FLD_VALUE;
                  ev    = EV_COLON;
               end else if (in_data.cls != CL_BLANK) begin
                  err = ERR_UNEXPECTED;
               end
            end
            FR_FLD_VALUE: begin
               open_req = 1'b1;
            end
            FR_ARR_OPEN, FR_ARR_DONE: begin
               if (in_data.cls == CL_COMMA) begin
                  act   = ACT_SET_TOP;
                  val_a = FR_ARR_OPEN;
                  ev    = EV_COMMA;
               end else if (in_data.cls == CL_RBRACK) begin
                  act = ACT_CLOSE;
                  ev  = EV_ARR_CLOSE;
               end else if (stk_ff[0] == FR_ARR_OPEN) begin
                  open_req = 1'b1;
               end else if (in_data.cls != CL_BLANK) begin
                  err = ERR_UNEXPECTED;
               end
            end
            FR_STR, FR_KEY: begin
               if (in_data.cls == CL_QUOTE) begin
                  act = ACT_CLOSE;
                  ev  = (stk_ff[0] == FR_KEY) ? EV_KEY_END : EV_STR_END;
               end else if (in_data.cls == CL_LBRACE || in_data.cls == CL_RBRACE ||
                            in_data.cls == CL_LBRACK || in_data.cls == CL_RBRACK) begin
                  err = ERR_BRACKET;
               end else begin
                  ev   = (stk_ff[0] == FR_KEY) ? EV_KEY_CHAR : EV_STR_CHAR;
                  echo = in_data.ch;
               end
            end
            default: begin
               err = ERR_UNEXPECTED;
            end
         endcase
      end

      // start of a value
      if (open_req) begin
         case (in_data.cls)
            CL_BLANK: ev = EV_BLANK;
            CL_LBRACE: begin
               act   = ACT_PUSH1;
               val_a = FR_OBJ_OPEN;
               ev    = EV_OBJ_OPEN;
            end
            CL_LBRACK: begin
               act   = ACT_PUSH1;
               val_a = FR_ARR_OPEN;
               ev    = EV_ARR_OPEN;
            end
            CL_QUOTE: begin
               act   = ACT_PUSH1;
               val_a = FR_STR;
               ev    = EV_STR_START;
            end
            default: err = ERR_UNEXPECTED;
         endcase
      end

      // depth check on pushes
      need    = (act == ACT_PUSH2) ? 2'd2 : 2'd1;
      sp_need = (DEPTH_W + 1)'(sp_ff) + (DEPTH_W + 1)'(need);
      if ((act == ACT_PUSH1 || act == ACT_PUSH2) && sp_need > {1'b0, lim_eff}) begin
         err = ERR_DEPTH;
      end

      // an erroneous character leaves the stack alone
      if (err != ERR_NONE) begin
         act  = ACT_NONE;
         ev   = EV_ERROR;
         echo = '0;
      end
   end

   // close of the top frame, cascading through a finished field
   always_comb begin
      up1     = parent_upd(stk_ff[1]);
      up2     = parent_upd(stk_ff[2]);
      cl_sh   = SH_POP1;
      cl_sp   = sp_ff - 1'b1;
      cl_root = root_ff;
      cl_upd  = '{wr: 1'b0, v: FR_OBJ_OPEN};
      if (sp_ff == SPW'(1)) begin
         cl_root = 1'b1;
      end else if (stk_ff[1] == FR_FLD_VALUE) begin
         cl_sh = SH_POP2;
         cl_sp = sp_ff - SPW'(2);
         if (sp_ff == SPW'(2)) begin
            cl_root = 1'b1;
         end else begin
            cl_upd = up2;
         end
      end else begin
         cl_upd = up1;
      end
   end

   // apply the step
   always_comb begin
      sh      = SH_HOLD;
      wr0     = 1'b0;
      wr1     = 1'b0;
      v0      = val_a;
      v1      = val_a;
      sp_in   = sp_ff;
      root_in = root_ff;
      err_in  = err_ff;
      code    = ERR_NONE;
      acc     = 1'b0;
      rsp_in  = rsp_ff;
      if (in_data.cmd) begin
         if (err_ff != ERR_NONE) begin
            code = err_ff;
         end else if (sp_ff != '0) begin
            code = ERR_UNCLOSED;
         end else if (!root_ff) begin
            code = ERR_EMPTY;
         end
         acc     = (code == ERR_NONE);
         sp_in   = '0;
         root_in = 1'b0;
         err_in  = ERR_NONE;
         rsp_in  = '{ev: EV_FINISHED, char_out: '0, depth: '0, code: code, accepted: acc};
      end else if (err_ff != ERR_NONE) begin
         rsp_in = '{ev: EV_ERROR, char_out: '0, depth: DEPTH_W'(sp_ff), code: err_ff,
                    accepted: 1'b0};
      end else begin
         err_in = err;
         case (act)
            ACT_PUSH1: begin
               sh    = SH_PUSH1;
               wr0   = 1'b1;
               v0    = val_a;
               sp_in = sp_ff + 1'b1;
            end
            ACT_PUSH2: begin
               sh    = SH_PUSH2;
               wr0   = 1'b1;
               v0    = val_b;
               wr1   = 1'b1;
               v1    = val_a;
               sp_in = sp_ff + SPW'(2);
            end
            ACT_SET_TOP: begin
               wr0 = 1'b1;
               v0  = val_a;
            end
            ACT_CLOSE: begin
               sh      = cl_sh;
               wr0     = cl_upd.wr;
               v0      = cl_upd.v;
               sp_in   = cl_sp;
               root_in = cl_root;
            end
            default: sh = SH_HOLD;
         endcase
         rsp_in = '{ev: ev, char_out: echo, depth: DEPTH_W'(sp_in), code: err,
                    accepted: 1'b0};
      end

      // shifted stack with the new top frames
      for (int i = 0; i < EFF; i++) begin
         case (sh)
            SH_POP2:  stk_in[i] = pad[i + 4];
            SH_POP1:  stk_in[i] = pad[i + 3];
            SH_PUSH1: stk_in[i] = pad[i + 1];
            SH_PUSH2: stk_in[i] = pad[i];
            default:  stk_in[i] = pad[i + 2];
         endcase
      end
      if (wr0) begin
         stk_in[0] = v0;
      end
      if (wr1) begin
         stk_in[1] = v1;
      end
   end

   // result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         root_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            sp_ff   <= sp_in;
            root_ff <= root_in;
            err_ff  <= err_in;
         end
      end
   end

   // stack and result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < EFF; i++) begin
            stk_ff[i] <= stk_in[i];
         end
      end
   end

endmodule

// ----- src/json_structure_validator_top.sv -----
// path: a request is stored in a queue entry, then the stack engine writes its result register
// throughput: one request per cycle while the response is taken, set by the update of the
// shift-register frame stack in the back end; a two-entry queue decouples the front
// reset: synchronous, clears stack pointer, root flag, error and queue, and sets the
// depth limit to 32; stack contents need no clearing pass
// top level: front classifier, request queue, stack engine and csr register
module json_structure_validator_top import jsv_pkg::*; #(
   parameter int MAX_DEPTH = 32,
   parameter int CHAR_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [15:0] ch
   input  logic               req_tuser,   // [0] cmd
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [15:0] char_out, [21:16] depth,
                                           // [24:22] error_code, [25] accepted
   output logic [3:0]         rsp_tuser,   // [3:0] event_res
   // configuration
   input  logic               csr_we,
   input  logic [DEPTH_W-1:0] csr_wdata
);

   logic [DEPTH_W-1:0] limit_ff, limit_in;
   entry_type          fr_entry;
   entry_type          q_data;
   logic               q_valid, q_ready;
   result_type         res;

   // depth limit register
   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // classify the incoming request
   jsv_front #(
      .CHAR_BITS (CHAR_BITS)
   ) u_front (
      .cmd   (req_tuser),
      .ch    (req_tdata),
      .entry (fr_entry)
   );

   // queue between front and back
   jsv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (fr_entry),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   // stack engine
   jsv_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (res)
   );

   // pack the response
   assign rsp_tuser = res.ev;
   assign rsp_tdata = {6'b0, res.accepted, res.code, res.depth, res.char_out};

`ifndef SYNTHESIS
   a_finish_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_FINISHED |-> rsp_tdata[21:16] == '0)
      else $error("finish result with nonzero depth");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tuser == EV_FINISHED && rsp_tdata[24:22] == ERR_NONE)
      else $error("accepted flag without a clean finish");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERROR |-> rsp_tdata[24:22] != ERR_NONE)
      else $error("error event without an error code");

   a_echo_only_content: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_KEY_CHAR && rsp_tuser != EV_STR_CHAR
      |-> rsp_tdata[15:0] == '0)
      else $error("character echoed outside string content");
`endif

endmodule
